### hdl/ale_pkg.sv
// Shared constants, codes and beat types for the array list engine.
package ale_pkg;

   localparam int CAPACITY = 16;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int POS_W    = 5;

   typedef enum logic [1:0] {
      MODE_INSERT = 2'd0,
      MODE_DELETE = 2'd1,
      MODE_READ   = 2'd2,
      MODE_FIND   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_BADPOS   = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_INSERT = 5'b00010,
      S_DELETE = 5'b00100,
      S_READ   = 5'b01000,
      S_FIND   = 5'b10000
   } state_type;

   typedef struct packed {
      mode_type                  mode;
      logic [POS_W-1:0]          position;
      logic signed [DATA_W-1:0]  value;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic signed [DATA_W-1:0]  data_out;
      logic [POS_W-1:0]          found_position;
      logic [POS_W-1:0]          list_length;
   } rsp_type;

endpackage

### hdl/array_list_engine.sv
// Ordered list of signed values in a RAM, with insert, delete, read and find.
//
//   channel   ports                         handshake
//   request   start, busy, req_item         beat taken when start && !busy
//   response  rsp_strobe, rsp_item          beat lives one cycle, no backpressure
//
// A rejected request answers on the cycle after it is taken and never raises busy.
// Read answers 2 cycles after it is taken. Insert and delete answer after
// (length - position + 4) cycles (insert at the end after 2), find after up to
// length + 3: the list RAM has one read and one write port, so one entry moves or is
// compared per cycle. Reset is synchronous; it empties the list (the RAM itself is
// not cleared). busy stays high from the cycle after a beat is taken until its reply.
module array_list_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ale_pkg::req_type req_item,
   output logic             rsp_strobe,
   output ale_pkg::rsp_type rsp_item
);

   localparam int AW = ale_pkg::ADDR_W;
   localparam int CW = ale_pkg::COUNT_W;
   localparam int PW = ale_pkg::POS_W;
   localparam int DW = ale_pkg::DATA_W;

   ale_pkg::state_type       state_ff, state_in;
   logic [CW-1:0]            count_ff, count_in;
   logic [AW-1:0]            addr_ff, addr_in;
   logic [CW-1:0]            left_ff, left_in;
   logic                     pend_ff, pend_in;
   logic [AW-1:0]            pend_addr_ff, pend_addr_in;
   logic                     first_ff, first_in;
   logic signed [DW-1:0]     data_ff, data_in;
   logic signed [DW-1:0]     value_ff, value_in;
   logic [AW-1:0]            slot_ff, slot_in;
   ale_pkg::rsp_type         rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic                     mem_we;
   logic [AW-1:0]            mem_waddr;
   logic [DW-1:0]            mem_wdata;
   logic [AW-1:0]            mem_raddr;
   logic [DW-1:0]            mem_rdata;

   logic [PW-1:0]            pos_m1;
   logic [PW:0]              pos_ext;
   logic [PW:0]              cnt_ext;

   function automatic ale_pkg::rsp_type make_rsp(ale_pkg::status_type st,
                                                 logic signed [DW-1:0] d,
                                                 logic [PW-1:0] f,
                                                 logic [CW-1:0] len);
      ale_pkg::rsp_type r;
      r.status         = st;
      r.data_out       = d;
      r.found_position = f;
      r.list_length    = PW'(len);
      return r;
   endfunction

   ale_ram #(
      .WIDTH(DW),
      .DEPTH(ale_pkg::CAPACITY)
   ) u_list_ram (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_addr(mem_raddr),
      .rd_data(mem_rdata)
   );

   assign pos_m1  = req_item.position - PW'(1);
   assign pos_ext = {1'b0, req_item.position};
   assign cnt_ext = (PW + 1)'(count_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      addr_in      = addr_ff;
      left_in      = left_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      first_in     = first_ff;
      data_in      = data_ff;
      value_in     = value_ff;
      slot_in      = slot_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = pend_addr_ff;
      mem_wdata    = mem_rdata;
      mem_raddr    = addr_ff;

      unique case (state_ff)
         ale_pkg::S_IDLE: begin
            if (start) begin
               value_in = req_item.value;
               slot_in  = AW'(pos_m1);
               unique case (req_item.mode)
                  ale_pkg::MODE_INSERT: begin
                     if (count_ff == CW'(ale_pkg::CAPACITY)) begin
                        rsp_in       = make_rsp(ale_pkg::ST_FULL, '0, '0, count_ff);
                        rsp_valid_in = 1'b1;
                     end else if (req_item.position == '0 ||
                                  pos_ext > cnt_ext + (PW + 1)'(1)) begin
                        rsp_in       = make_rsp(ale_pkg::ST_BADPOS, '0, '0, count_ff);
                        rsp_valid_in = 1'b1;
                     end else begin
                        // shift from the top entry down to the insert slot
                        state_in = ale_pkg::S_INSERT;
                        addr_in  = AW'(count_ff - CW'(1));
                        left_in  = count_ff - CW'(pos_m1);
                     end
                  end
                  ale_pkg::MODE_DELETE,
                  ale_pkg::MODE_READ: begin
                     if (count_ff == '0) begin
                        rsp_in       = make_rsp(ale_pkg::ST_EMPTY, '0, '0, count_ff);
                        rsp_valid_in = 1'b1;
                     end else if (req_item.position == '0 || pos_ext > cnt_ext) begin
                        rsp_in       = make_rsp(ale_pkg::ST_BADPOS, '0, '0, count_ff);
                        rsp_valid_in = 1'b1;
                     end else if (req_item.mode == ale_pkg::MODE_READ) begin
                        mem_raddr = AW'(pos_m1);
                        state_in  = ale_pkg::S_READ;
                     end else begin
                        state_in = ale_pkg::S_DELETE;
                        addr_in  = AW'(pos_m1);
                        left_in  = count_ff - CW'(pos_m1);
                        first_in = 1'b1;
                     end
                  end
                  ale_pkg::MODE_FIND: begin
                     state_in = ale_pkg::S_FIND;
                     addr_in  = '0;
                     left_in  = count_ff;
                  end
               endcase
            end
         end

         ale_pkg::S_INSERT: begin
            if (left_ff != '0) begin
               mem_raddr    = addr_ff;
               addr_in      = addr_ff - AW'(1);
               left_in      = left_ff - CW'(1);
               pend_in      = 1'b1;
               pend_addr_in = addr_ff + AW'(1);
            end
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = pend_addr_ff;
               mem_wdata = mem_rdata;
            end else if (left_ff == '0) begin
               // all moves done: drop the new value into its slot
               mem_we       = 1'b1;
               mem_waddr    = slot_ff;
               mem_wdata    = value_ff;
               count_in     = count_ff + CW'(1);
               rsp_in       = make_rsp(ale_pkg::ST_OK, '0, '0, count_ff + CW'(1));
               rsp_valid_in = 1'b1;
               state_in     = ale_pkg::S_IDLE;
            end
         end

         ale_pkg::S_DELETE: begin
            if (left_ff != '0) begin
               mem_raddr    = addr_ff;
               addr_in      = addr_ff + AW'(1);
               left_in      = left_ff - CW'(1);
               pend_in      = 1'b1;
               pend_addr_in = addr_ff;
            end
            if (pend_ff) begin
               if (first_ff) begin
                  // first beat back is the removed entry
                  data_in  = mem_rdata;
                  first_in = 1'b0;
               end else begin
                  mem_we    = 1'b1;
                  mem_waddr = pend_addr_ff - AW'(1);
                  mem_wdata = mem_rdata;
               end
            end else if (left_ff == '0) begin
               count_in     = count_ff - CW'(1);
               rsp_in       = make_rsp(ale_pkg::ST_OK, data_ff, '0, count_ff - CW'(1));
               rsp_valid_in = 1'b1;
               state_in     = ale_pkg::S_IDLE;
            end
         end

         ale_pkg::S_READ: begin
            rsp_in       = make_rsp(ale_pkg::ST_OK, mem_rdata, '0, count_ff);
            rsp_valid_in = 1'b1;
            state_in     = ale_pkg::S_IDLE;
         end

         ale_pkg::S_FIND: begin
            if (pend_ff && mem_rdata == value_ff) begin
               rsp_in       = make_rsp(ale_pkg::ST_OK, '0,
                                       PW'(pend_addr_ff) + PW'(1), count_ff);
               rsp_valid_in = 1'b1;
               state_in     = ale_pkg::S_IDLE;
            end else if (left_ff != '0) begin
               mem_raddr    = addr_ff;
               addr_in      = addr_ff + AW'(1);
               left_in      = left_ff - CW'(1);
               pend_in      = 1'b1;
               pend_addr_in = addr_ff;
            end else if (!pend_ff) begin
               rsp_in       = make_rsp(ale_pkg::ST_NOTFOUND, '0, '0, count_ff);
               rsp_valid_in = 1'b1;
               state_in     = ale_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = ale_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ale_pkg::S_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      addr_ff      <= addr_in;
      left_ff      <= left_in;
      pend_addr_ff <= pend_addr_in;
      first_ff     <= first_in;
      data_ff      <= data_in;
      value_ff     <= value_in;
      slot_ff      <= slot_in;
      rsp_ff       <= rsp_in;
   end

   assign busy       = (state_ff != ale_pkg::S_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

   // a reply always closes out the sequencer
   a_reply_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == ale_pkg::S_IDLE)
      else $error("reply beat while sequencer still active");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(ale_pkg::CAPACITY))
      else $error("list length beyond capacity");

   a_start_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_strobe)
      else $error("accepted beat neither started nor answered");

   a_no_idle_write: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> state_ff == ale_pkg::S_INSERT || state_ff == ale_pkg::S_DELETE)
      else $error("list RAM written outside insert or delete");

endmodule

### hdl/ale_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ale_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
